/* hw/rtl/hsv_to_rgb_pixel_unit_macros.svh */
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit_macros.svh
// Assertion macros shared by the HSV to RGB pixel unit RTL.
// The macros expect signals named clk and rst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_UNIT_MACROS_SVH
`define HSV_TO_RGB_PIXEL_UNIT_MACROS_SVH

// Check that prop holds in the same cycle whenever cond holds
`define HSV_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that prop holds in the cycle after cond holds
`define HSV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hw/rtl/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Widths, fixed-point constants and hue sector codes for the HSV to RGB unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // Fractional bits of all intermediate fractions
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int HUE_W  = 13;
    localparam int PCT_W  = 15;
    localparam int CHAN_W = 8;
    localparam int HM_W   = 11;   // hue modulo 120 degrees, below 1920

    // Stream data widths, padded to whole bytes
    localparam int IN_FIELDS_W  = HUE_W + 2 * PCT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * CHAN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Scale constants
    localparam int FULL_PERCENT = 25600;
    localparam int SIXTY_DEG    = 960;
    localparam int HUE_PERIOD   = 2 * SIXTY_DEG;
    localparam int CHAN_MAX     = 255;

    // Unsigned fraction with one integer bit, holds 0.0 up to 1.0 and more
    typedef logic [FRAC_BITS:0] frac_t;
    localparam frac_t FRAC_ONE = frac_t'(64'd1 << FRAC_BITS);

    // Percent to fraction: floor(x * 2^F / 25600) via floor reciprocal
    localparam int PCT_K        = PCT_W + FRAC_BITS;
    localparam int PCT_SHIFT    = PCT_K - FRAC_BITS;
    localparam int PCT_RECIP_W  = FRAC_BITS + 1;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
        PCT_RECIP_W'((64'd1 << PCT_K) / FULL_PERCENT);
    localparam int PCT_PROD_W   = PCT_W + PCT_RECIP_W;
    localparam int PCT_CHK_W    = PCT_W + FRAC_BITS + 1;

    // Hue position: floor(hm * 2^F / 960) via floor reciprocal
    localparam int HUE_K        = HM_W + FRAC_BITS;
    localparam int HUE_SHIFT    = HUE_K - FRAC_BITS;
    localparam int HUE_RECIP_W  = FRAC_BITS + 2;
    localparam logic [HUE_RECIP_W-1:0] HUE_RECIP =
        HUE_RECIP_W'((64'd1 << HUE_K) / SIXTY_DEG);
    localparam int HUE_PROD_W   = HM_W + HUE_RECIP_W;
    localparam int HUE_CHK_W    = HM_W + FRAC_BITS + 1;

    // Hue sectors of 60 degrees; everything from 300 degrees up is the last
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

endpackage

`default_nettype wire

/* hw/rtl/hsv_to_rgb_pixel_unit.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_unit
// Stream HSV to 8-bit RGB, six-stage pipeline, one item per unstalled cycle.
// ----------------------------------------------------------------------------
// The unit takes one HSV item per clock unless stalled and returns one RGB
// item for each, in order. The result is presented from the last stage's
// output register and taken when the output does not stall. Throughput is
// one item per cycle while nothing stalls; the six register stages are clamp
// and hue reduction, reciprocal multiply, quotient correction, chroma
// multiply, X multiply, and channel scaling into the output register. Each
// stage holds only while the stage after it is full and stalled, so empty
// stages keep taking items while a result waits at the output. Hue is in
// 1/16 degree; any hue from 300 degrees up uses the magenta-to-red sector.
// Saturation and value above 100 percent are held to 100 percent. There is
// no stored state beyond the pipeline.
`default_nettype none

`include "hsv_to_rgb_pixel_unit_macros.svh"

module hsv_to_rgb_pixel_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: hue[12:0], saturation[27:13], brightness[42:28], zero pad
    input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import hsvrgb_pkg::*;

    localparam int NSTAGES = 6;
    localparam int LAST    = NSTAGES - 1;

    // Stage control
    logic [NSTAGES-1:0] vld_reg;
    logic [NSTAGES-1:0] vld_next;
    logic [NSTAGES-1:0] en;

    // Stage 1: clamped inputs, hue mod 120 degrees, sector
    logic [HUE_W-1:0] hue_in;
    logic [PCT_W-1:0] sat_in;
    logic [PCT_W-1:0] bri_in;
    logic [PCT_W-1:0] sat1_next, sat1_reg;
    logic [PCT_W-1:0] bri1_next, bri1_reg;
    logic [HM_W-1:0]  hm1_next, hm1_reg;
    sector_t          sect1_next, sect1_reg;

    // Stage 2: estimated quotients
    logic [PCT_PROD_W-1:0] s_prod, v_prod;
    logic [HUE_PROD_W-1:0] t_prod;
    frac_t            sq2_next, sq2_reg;
    frac_t            vq2_next, vq2_reg;
    frac_t            tq2_next, tq2_reg;
    logic [PCT_W-1:0] sat2_reg, bri2_reg;
    logic [HM_W-1:0]  hm2_reg;
    sector_t          sect2_reg;

    // Stage 3: corrected fractions
    logic [PCT_CHK_W-1:0] s_num, s_bound, v_num, v_bound;
    logic [HUE_CHK_W-1:0] t_num, t_bound;
    frac_t   s3_next, s3_reg;
    frac_t   v3_next, v3_reg;
    frac_t   t3_next, t3_reg;
    sector_t sect3_reg;

    // Stage 4: chroma and the hue ramp
    logic [2*FRAC_BITS+1:0] sv_prod;
    frac_t   hue_dist;
    frac_t   c4_next, c4_reg;
    frac_t   omd4_next, omd4_reg;
    frac_t   v4_reg;
    sector_t sect4_reg;

    // Stage 5: X and offset
    logic [2*FRAC_BITS+1:0] cx_prod;
    frac_t   x5_next, x5_reg;
    frac_t   m5_next, m5_reg;
    frac_t   c5_reg;
    sector_t sect5_reg;

    // Stage 6: output channels
    frac_t             r_comp, g_comp, b_comp;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[LAST] = !vld_reg[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NSTAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[LAST];

    // ---- Stage 1 ----
    assign hue_in = s_axis_tdata[HUE_W-1:0];
    assign sat_in = s_axis_tdata[HUE_W +: PCT_W];
    assign bri_in = s_axis_tdata[HUE_W+PCT_W +: PCT_W];

    // Hold percent values to 100 percent
    assign sat1_next = (sat_in > PCT_W'(FULL_PERCENT)) ? PCT_W'(FULL_PERCENT) : sat_in;
    assign bri1_next = (bri_in > PCT_W'(FULL_PERCENT)) ? PCT_W'(FULL_PERCENT) : bri_in;

    // Reduce hue modulo 120 degrees
    always_comb
    begin
        if (hue_in >= HUE_W'(4 * HUE_PERIOD))
        begin
            hm1_next = HM_W'(hue_in - HUE_W'(4 * HUE_PERIOD));
        end
        else if (hue_in >= HUE_W'(3 * HUE_PERIOD))
        begin
            hm1_next = HM_W'(hue_in - HUE_W'(3 * HUE_PERIOD));
        end
        else if (hue_in >= HUE_W'(2 * HUE_PERIOD))
        begin
            hm1_next = HM_W'(hue_in - HUE_W'(2 * HUE_PERIOD));
        end
        else if (hue_in >= HUE_W'(HUE_PERIOD))
        begin
            hm1_next = HM_W'(hue_in - HUE_W'(HUE_PERIOD));
        end
        else
        begin
            hm1_next = HM_W'(hue_in);
        end
    end

    // Pick the sector; hues from 300 degrees up share the last one
    always_comb
    begin
        if (hue_in < HUE_W'(SIXTY_DEG))
        begin
            sect1_next = SECT_RY;
        end
        else if (hue_in < HUE_W'(2 * SIXTY_DEG))
        begin
            sect1_next = SECT_YG;
        end
        else if (hue_in < HUE_W'(3 * SIXTY_DEG))
        begin
            sect1_next = SECT_GC;
        end
        else if (hue_in < HUE_W'(4 * SIXTY_DEG))
        begin
            sect1_next = SECT_CB;
        end
        else if (hue_in < HUE_W'(5 * SIXTY_DEG))
        begin
            sect1_next = SECT_BM;
        end
        else
        begin
            sect1_next = SECT_MR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat1_reg  <= sat1_next;
            bri1_reg  <= bri1_next;
            hm1_reg   <= hm1_next;
            sect1_reg <= sect1_next;
        end
    end

    // ---- Stage 2 ----
    // Multiply by floor reciprocals; the quotient may be one short
    assign s_prod = PCT_PROD_W'(sat1_reg) * PCT_PROD_W'(PCT_RECIP);
    assign v_prod = PCT_PROD_W'(bri1_reg) * PCT_PROD_W'(PCT_RECIP);
    assign t_prod = HUE_PROD_W'(hm1_reg) * HUE_PROD_W'(HUE_RECIP);

    assign sq2_next = s_prod[PCT_SHIFT +: FRAC_BITS+1];
    assign vq2_next = v_prod[PCT_SHIFT +: FRAC_BITS+1];
    assign tq2_next = t_prod[HUE_SHIFT +: FRAC_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sq2_reg   <= sq2_next;
            vq2_reg   <= vq2_next;
            tq2_reg   <= tq2_next;
            sat2_reg  <= sat1_reg;
            bri2_reg  <= bri1_reg;
            hm2_reg   <= hm1_reg;
            sect2_reg <= sect1_reg;
        end
    end

    // ---- Stage 3 ----
    // Bump the quotient when the next multiple still fits under the numerator
    assign s_num   = PCT_CHK_W'(sat2_reg) << FRAC_BITS;
    assign v_num   = PCT_CHK_W'(bri2_reg) << FRAC_BITS;
    assign t_num   = HUE_CHK_W'(hm2_reg) << FRAC_BITS;
    assign s_bound = PCT_CHK_W'((PCT_CHK_W'(sq2_reg) + 1'b1) * PCT_CHK_W'(FULL_PERCENT));
    assign v_bound = PCT_CHK_W'((PCT_CHK_W'(vq2_reg) + 1'b1) * PCT_CHK_W'(FULL_PERCENT));
    assign t_bound = HUE_CHK_W'((HUE_CHK_W'(tq2_reg) + 1'b1) * HUE_CHK_W'(SIXTY_DEG));

    assign s3_next = (s_num >= s_bound) ? frac_t'(sq2_reg + 1'b1) : sq2_reg;
    assign v3_next = (v_num >= v_bound) ? frac_t'(vq2_reg + 1'b1) : vq2_reg;
    assign t3_next = (t_num >= t_bound) ? frac_t'(tq2_reg + 1'b1) : tq2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg    <= s3_next;
            v3_reg    <= v3_next;
            t3_reg    <= t3_next;
            sect3_reg <= sect2_reg;
        end
    end

    // ---- Stage 4 ----
    // Chroma is s * v; the ramp is one minus the distance of t from one
    assign sv_prod = (2*FRAC_BITS+2)'(s3_reg) * (2*FRAC_BITS+2)'(v3_reg);
    assign c4_next = sv_prod[2*FRAC_BITS:FRAC_BITS];
    assign hue_dist = (t3_reg >= FRAC_ONE) ? frac_t'(t3_reg - FRAC_ONE)
                                           : frac_t'(FRAC_ONE - t3_reg);
    assign omd4_next = frac_t'(FRAC_ONE - hue_dist);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c4_reg    <= c4_next;
            omd4_reg  <= omd4_next;
            v4_reg    <= v3_reg;
            sect4_reg <= sect3_reg;
        end
    end

    // ---- Stage 5 ----
    assign cx_prod = (2*FRAC_BITS+2)'(c4_reg) * (2*FRAC_BITS+2)'(omd4_reg);
    assign x5_next = cx_prod[2*FRAC_BITS:FRAC_BITS];
    assign m5_next = (v4_reg >= c4_reg) ? frac_t'(v4_reg - c4_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            x5_reg    <= x5_next;
            m5_reg    <= m5_next;
            c5_reg    <= c4_reg;
            sect5_reg <= sect4_reg;
        end
    end

    // ---- Stage 6 ----
    // Route chroma and X to the channels by sector
    always_comb
    begin
        unique case (sect5_reg)
            SECT_RY:
            begin
                r_comp = c5_reg; g_comp = x5_reg; b_comp = '0;
            end
            SECT_YG:
            begin
                r_comp = x5_reg; g_comp = c5_reg; b_comp = '0;
            end
            SECT_GC:
            begin
                r_comp = '0; g_comp = c5_reg; b_comp = x5_reg;
            end
            SECT_CB:
            begin
                r_comp = '0; g_comp = x5_reg; b_comp = c5_reg;
            end
            SECT_BM:
            begin
                r_comp = x5_reg; g_comp = '0; b_comp = c5_reg;
            end
            default:
            begin
                r_comp = c5_reg; g_comp = '0; b_comp = x5_reg;
            end
        endcase
    end

    hsvrgb_chan u_chan_red (
        .comp   (r_comp),
        .offset (m5_reg),
        .chan   (red_next)
    );

    hsvrgb_chan u_chan_green (
        .comp   (g_comp),
        .offset (m5_reg),
        .chan   (green_next)
    );

    hsvrgb_chan u_chan_blue (
        .comp   (b_comp),
        .offset (m5_reg),
        .chan   (blue_next)
    );

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tdata = OUT_TDATA_W'({blue_reg, green_reg, red_reg});

    // ---- Assertions ----
    `HSV_ASSERT_IMPLY(a_ready_when_out_empty, !vld_reg[LAST], s_axis_tready,
        "input not ready while the output stage is empty")
    `HSV_ASSERT_NEXT(a_accept_fills_stage1, s_axis_tvalid && s_axis_tready, vld_reg[0],
        "accepted item did not enter the first stage")
    `HSV_ASSERT_IMPLY(a_fraction_range, vld_reg[2],
        (s3_reg <= FRAC_ONE) && (v3_reg <= FRAC_ONE),
        "saturation or value fraction above one")
    `HSV_ASSERT_IMPLY(a_chroma_le_value, vld_reg[3], c4_reg <= v4_reg,
        "chroma exceeds value")

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_chan.sv */
// ----------------------------------------------------------------------------
// hsvrgb_chan
// One output channel: (component + offset) * 255, truncated and held to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_chan (
    input  hsvrgb_pkg::frac_t                  comp,
    input  hsvrgb_pkg::frac_t                  offset,
    output logic [hsvrgb_pkg::CHAN_W-1:0]      chan
);
    import hsvrgb_pkg::*;

    localparam int SUM_W   = FRAC_BITS + 2;
    localparam int SCALE_W = SUM_W + CHAN_W;
    localparam int TOP_W   = SCALE_W - FRAC_BITS;

    logic [SUM_W-1:0]   sum;
    logic [SCALE_W-1:0] scaled;
    logic [TOP_W-1:0]   top;

    // Add the offset, scale by 255 as a shift and subtract
    assign sum    = SUM_W'(comp) + SUM_W'(offset);
    assign scaled = (SCALE_W'(sum) << CHAN_W) - SCALE_W'(sum);
    assign top    = scaled[SCALE_W-1:FRAC_BITS];

    // Hold to full scale
    assign chan = (top > TOP_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : top[CHAN_W-1:0];

endmodule

`default_nettype wire
